// ===== rtl/core/lppe_pkg.sv =====
// Shared types, constants and helpers for the LED pixel PWM encoder.
// Used by every module in rtl/core; depends on nothing else.
`default_nettype none

package lppe_pkg;

  localparam int unsigned ChanW        = 8;
  localparam int unsigned DutyW        = 8;
  localparam int unsigned BitsPerPixel = 3 * ChanW;
  localparam int unsigned BitCntW      = $clog2(BitsPerPixel + 1);
  localparam int unsigned RegionW      = 3;
  localparam int unsigned CfgIdxW      = 2;
  localparam int unsigned CfgDataW     = 8;

  localparam logic [ChanW-1:0] HueStep  = 8'd43;
  localparam logic [ChanW-1:0] ChanMax  = 8'd255;

  // Register indexes of the configuration port.
  localparam logic [CfgIdxW-1:0] CFG_COLOR_MODE = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_HIGH_DUTY  = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_LOW_DUTY   = 2'd2;

  localparam logic [DutyW-1:0] HighDutyReset = 8'd85;
  localparam logic [DutyW-1:0] LowDutyReset  = 8'd34;
  localparam logic [DutyW-1:0] FrameEndDuty  = 8'd0;

  // Input beat: one pixel.
  typedef struct packed {
    logic [ChanW-1:0] chan_a;
    logic [ChanW-1:0] chan_b;
    logic [ChanW-1:0] chan_c;
    logic             last_pixel;
  } pix_in_t;

  // Output beat: one duty word.
  typedef struct packed {
    logic [DutyW-1:0] duty;
    logic             last;
  } word_out_t;

  // Configuration as seen by the datapath.
  typedef struct packed {
    logic             color_mode;
    logic [DutyW-1:0] high_duty;
    logic [DutyW-1:0] low_duty;
  } cfg_t;

  // Converted pixel handed to the serialiser, red in the top byte.
  typedef struct packed {
    logic [BitsPerPixel-1:0] bits;
    logic                    fin;
  } rgb_pix_t;

  // Hue region 0..5: regions 0..4 span 43 hue steps each, region 5 runs from 215 to 255.
  function automatic logic [RegionW-1:0] hue_region(input logic [ChanW-1:0] h);
    logic [RegionW-1:0] r;
    priority if (h >= 8'(5 * HueStep)) r = 3'd5;
    else if (h >= 8'(4 * HueStep))     r = 3'd4;
    else if (h >= 8'(3 * HueStep))     r = 3'd3;
    else if (h >= 8'(2 * HueStep))     r = 3'd2;
    else if (h >= HueStep)             r = 3'd1;
    else                               r = 3'd0;
    return r;
  endfunction

  // Start of a hue region.
  function automatic logic [ChanW-1:0] region_base(input logic [RegionW-1:0] r);
    logic [ChanW-1:0] b;
    unique case (r)
      3'd0:    b = 8'd0;
      3'd1:    b = HueStep;
      3'd2:    b = 8'(2 * HueStep);
      3'd3:    b = 8'(3 * HueStep);
      3'd4:    b = 8'(4 * HueStep);
      default: b = 8'(5 * HueStep);
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/lppe_hsv_pipe.sv =====
// Four-stage colour conversion pipeline: hue/saturation/value to RGB or passthrough.
// Depends on lppe_pkg.
`default_nettype none

module lppe_hsv_pipe (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire lppe_pkg::cfg_t     cfg_i,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire lppe_pkg::pix_in_t  in_pix_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output lppe_pkg::rgb_pix_t      out_pix_o
);

  typedef struct packed {
    logic [lppe_pkg::RegionW-1:0] region;
    logic [lppe_pkg::ChanW-1:0]   rem6;
    logic [lppe_pkg::ChanW-1:0]   s_inv;
    logic                         s_zero;
    lppe_pkg::pix_in_t            pix;
  } st1_t;

  typedef struct packed {
    logic [lppe_pkg::RegionW-1:0] region;
    logic [lppe_pkg::ChanW-1:0]   p;
    logic [lppe_pkg::ChanW-1:0]   sr;
    logic [lppe_pkg::ChanW-1:0]   srr;
    logic                         s_zero;
    lppe_pkg::pix_in_t            pix;
  } st2_t;

  typedef struct packed {
    logic [lppe_pkg::RegionW-1:0] region;
    logic [lppe_pkg::ChanW-1:0]   p;
    logic [lppe_pkg::ChanW-1:0]   q;
    logic [lppe_pkg::ChanW-1:0]   t;
    logic                         s_zero;
    lppe_pkg::pix_in_t            pix;
  } st3_t;

  logic v1_q, v2_q, v3_q, v4_q;
  logic rdy1, rdy2, rdy3, rdy4;
  st1_t s1_d, s1_q;
  st2_t s2_d, s2_q;
  st3_t s3_d, s3_q;
  lppe_pkg::rgb_pix_t s4_d, s4_q;

  assign rdy4 = !v4_q || out_ready_i;
  assign rdy3 = !v3_q || rdy4;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;

  assign in_stall_o  = !rdy1;
  assign out_valid_o = v4_q;
  assign out_pix_o   = s4_q;

  // Stage 1: hue region and the scaled remainder within it.
  logic [lppe_pkg::RegionW-1:0] reg1;
  logic [lppe_pkg::ChanW-1:0]   rem1;
  always_comb begin
    reg1        = lppe_pkg::hue_region(in_pix_i.chan_a);
    rem1        = in_pix_i.chan_a - lppe_pkg::region_base(reg1);
    s1_d.region = reg1;
    s1_d.rem6   = 8'(rem1 * 8'd6);
    s1_d.s_inv  = lppe_pkg::ChanMax - in_pix_i.chan_b;
    s1_d.s_zero = (in_pix_i.chan_b == '0);
    s1_d.pix    = in_pix_i;
  end

  // Stage 2: first round of 8x8 products.
  logic [2*lppe_pkg::ChanW-1:0] p_full, sr_full, srr_full;
  always_comb begin
    p_full      = s1_q.pix.chan_c * s1_q.s_inv;
    sr_full     = s1_q.pix.chan_b * s1_q.rem6;
    srr_full    = s1_q.pix.chan_b * (lppe_pkg::ChanMax - s1_q.rem6);
    s2_d.region = s1_q.region;
    s2_d.p      = p_full[2*lppe_pkg::ChanW-1:lppe_pkg::ChanW];
    s2_d.sr     = sr_full[2*lppe_pkg::ChanW-1:lppe_pkg::ChanW];
    s2_d.srr    = srr_full[2*lppe_pkg::ChanW-1:lppe_pkg::ChanW];
    s2_d.s_zero = s1_q.s_zero;
    s2_d.pix    = s1_q.pix;
  end

  // Stage 3: second round of products gives q and t.
  logic [2*lppe_pkg::ChanW-1:0] q_full, t_full;
  always_comb begin
    q_full      = s2_q.pix.chan_c * (lppe_pkg::ChanMax - s2_q.sr);
    t_full      = s2_q.pix.chan_c * (lppe_pkg::ChanMax - s2_q.srr);
    s3_d.region = s2_q.region;
    s3_d.p      = s2_q.p;
    s3_d.q      = q_full[2*lppe_pkg::ChanW-1:lppe_pkg::ChanW];
    s3_d.t      = t_full[2*lppe_pkg::ChanW-1:lppe_pkg::ChanW];
    s3_d.s_zero = s2_q.s_zero;
    s3_d.pix    = s2_q.pix;
  end

  // Stage 4: pick the colour order for the region, grey when saturation is zero, or the raw channels.
  logic [lppe_pkg::ChanW-1:0] r4, g4, b4, v4;
  always_comb begin
    v4 = s3_q.pix.chan_c;
    unique case (s3_q.region)
      3'd0:    begin r4 = v4;      g4 = s3_q.t; b4 = s3_q.p; end
      3'd1:    begin r4 = s3_q.q;  g4 = v4;     b4 = s3_q.p; end
      3'd2:    begin r4 = s3_q.p;  g4 = v4;     b4 = s3_q.t; end
      3'd3:    begin r4 = s3_q.p;  g4 = s3_q.q; b4 = v4;     end
      3'd4:    begin r4 = s3_q.t;  g4 = s3_q.p; b4 = v4;     end
      default: begin r4 = v4;      g4 = s3_q.p; b4 = s3_q.q; end
    endcase
    if (!cfg_i.color_mode) begin
      r4 = s3_q.pix.chan_a;
      g4 = s3_q.pix.chan_b;
      b4 = s3_q.pix.chan_c;
    end else if (s3_q.s_zero) begin
      r4 = v4;
      g4 = v4;
      b4 = v4;
    end
    s4_d.bits = {r4, g4, b4};
    s4_d.fin  = s3_q.pix.last_pixel;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= in_valid_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1 && in_valid_i) s1_q <= s1_d;
    if (rdy2 && v1_q)       s2_q <= s2_d;
    if (rdy3 && v2_q)       s3_q <= s3_d;
    if (rdy4 && v3_q)       s4_q <= s4_d;
  end

endmodule

`default_nettype wire

// ===== rtl/core/lppe_serial.sv =====
// Bit serialiser: turns one RGB pixel into 24 duty words plus an optional frame-end word.
// Depends on lppe_pkg.
`default_nettype none

module lppe_serial (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire lppe_pkg::cfg_t      cfg_i,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire lppe_pkg::rgb_pix_t  in_pix_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output lppe_pkg::word_out_t      out_word_o
);

  localparam logic [lppe_pkg::BitCntW-1:0] LastBit =
    lppe_pkg::BitCntW'(lppe_pkg::BitsPerPixel - 1);
  localparam logic [lppe_pkg::BitCntW-1:0] EndWord =
    lppe_pkg::BitCntW'(lppe_pkg::BitsPerPixel);

  logic                             busy_q, busy_d;
  logic [lppe_pkg::BitCntW-1:0]     cnt_q, cnt_d;
  logic [lppe_pkg::BitsPerPixel-1:0] bits_q, bits_d;
  logic                             fin_q, fin_d;
  logic                             take, final_word, end_word;

  assign end_word   = (cnt_q == EndWord);
  assign final_word = end_word || ((cnt_q == LastBit) && !fin_q);
  assign take       = busy_q && !out_stall_i;
  assign in_ready_o = !busy_q || (take && final_word);

  assign out_valid_o     = busy_q;
  assign out_word_o.last = final_word;
  assign out_word_o.duty = end_word ? lppe_pkg::FrameEndDuty :
                           (bits_q[lppe_pkg::BitsPerPixel-1] ? cfg_i.high_duty
                                                              : cfg_i.low_duty);

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    bits_d = bits_q;
    fin_d  = fin_q;
    if (take) begin
      cnt_d  = cnt_q + 1'b1;
      bits_d = {bits_q[lppe_pkg::BitsPerPixel-2:0], 1'b0};
      if (final_word) busy_d = 1'b0;
    end
    if (in_ready_o && in_valid_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      bits_d = in_pix_i.bits;
      fin_d  = in_pix_i.fin;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bits_q <= bits_d;
    fin_q  <= fin_d;
  end

endmodule

`default_nettype wire

// ===== rtl/core/led_pixel_pwm_encoder.sv =====
// Top level of the LED pixel PWM encoder: configuration registers, conversion pipeline
// and bit serialiser. Depends on lppe_pkg, lppe_hsv_pipe and lppe_serial.
//
//   Channel   Direction  Handshake               Beat
//   in        sink       in_valid_i / in_stall_o  one pixel (lppe_pkg::pix_in_t)
//   out       source     out_valid_o / out_stall_i one duty word (lppe_pkg::word_out_t)
//   cfg       sink       cfg_valid_i / cfg_ready_o register index and write data
//
// A pixel passes the conversion pipeline and then the serialiser, which turns it into 24
// duty words, 25 when it closes a frame; the serialiser, emitting one duty word per
// cycle while out_stall_i is low, sets the sustained pixel rate.
// The next pixel is loaded in the same cycle as the final word of the previous one is
// taken, so words leave without gaps while the far side keeps stall low.
// A stall on the output simply holds the current word; the pipeline behind it fills
// and then stalls the input. Reset clears all valid state and loads the register defaults.
`default_nettype none

module led_pixel_pwm_encoder (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             in_valid_i,
  output logic                                  in_stall_o,
  input  wire lppe_pkg::pix_in_t                in_pix_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_stall_i,
  output lppe_pkg::word_out_t                   out_word_o,
  input  wire logic                             cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  wire logic [lppe_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  wire logic [lppe_pkg::CfgDataW-1:0]    cfg_data_i
);

  lppe_pkg::cfg_t     cfg_q, cfg_d;
  logic               pipe_valid;
  logic               ser_ready;
  lppe_pkg::rgb_pix_t pipe_pix;

  // Registers are always writable; writes to an unused index are dropped.
  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        lppe_pkg::CFG_COLOR_MODE: cfg_d.color_mode = cfg_data_i[0];
        lppe_pkg::CFG_HIGH_DUTY:  cfg_d.high_duty  = cfg_data_i;
        lppe_pkg::CFG_LOW_DUTY:   cfg_d.low_duty   = cfg_data_i;
        default:                  cfg_d            = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.color_mode <= 1'b0;
      cfg_q.high_duty  <= lppe_pkg::HighDutyReset;
      cfg_q.low_duty   <= lppe_pkg::LowDutyReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Colour conversion: four register stages, one pixel may enter each cycle unless in_stall_o is raised.
  lppe_hsv_pipe u_hsv_pipe (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_pix_i    (in_pix_i),
    .out_valid_o (pipe_valid),
    .out_ready_i (ser_ready),
    .out_pix_o   (pipe_pix)
  );

  // Serialiser: shifts the 24 colour bits out MSB first as duty words.
  lppe_serial u_serial (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (pipe_valid),
    .in_ready_o  (ser_ready),
    .in_pix_i    (pipe_pix),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

endmodule

`default_nettype wire

// ===== verif/tb_top.sv =====
// Self-checking bench for led_pixel_pwm_encoder: a directed table of pixels, a back-pressure run, then random frames.
// Each duty word is checked against an in-bench colour conversion and bit serialiser.
// Depends on lppe_pkg and the encoder RTL only.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import lppe_pkg::*;

  // Index 3 is not mapped to any register, so writes to it must change nothing.
  localparam logic [CfgIdxW-1:0] CfgSpare = 2'd3;
  localparam logic [DutyW-1:0]   DutyTop  = 8'd179;
  localparam int unsigned        MaxGap   = 6;
  // Long receiver hold-off, so that the conversion pipeline fills and stalls the input.
  localparam int unsigned        PressureHold   = 200;
  localparam int unsigned        PressurePixels = 12;
  localparam int unsigned        RandomPhases   = 5;
  localparam int unsigned        PixelsPerPhase = 42;
  localparam int unsigned        SettleCycles   = 16;

  localparam cfg_t CfgReset    = '{1'b0, HighDutyReset, LowDutyReset};
  localparam cfg_t CfgHsv      = '{1'b1, DutyTop, 8'd0};
  localparam cfg_t CfgWide     = '{1'b0, 8'hFF, 8'hFF};
  localparam cfg_t CfgZeroHigh = '{1'b0, 8'd0, DutyTop};
  localparam cfg_t CfgMix      = '{1'b1, 8'd60, 8'd120};

  // One row of the directed table. Where the colour is obvious (passthrough, grey, black)
  // it is typed in; otherwise the conversion below works it out.
  typedef struct {
    bit                      load_cfg;
    cfg_t                    cfg;
    pix_in_t                 pix;
    bit                      known;
    logic [BitsPerPixel-1:0] rgb;
  } plan_row_t;

  plan_row_t plan [20] = '{
    // Reset values of the registers, RGB passthrough.
    '{1'b0, CfgReset,    '{8'h00, 8'h00, 8'h00, 1'b0}, 1'b1, 24'h000000},
    '{1'b0, CfgReset,    '{8'hFF, 8'hFF, 8'hFF, 1'b1}, 1'b1, 24'hFFFFFF},
    '{1'b0, CfgReset,    '{8'hA5, 8'h5A, 8'h0F, 1'b0}, 1'b1, 24'hA55A0F},
    '{1'b0, CfgReset,    '{8'h80, 8'h01, 8'h7E, 1'b1}, 1'b1, 24'h80017E},
    // Hue, saturation and value: grey first, then the start of every hue region and the ends of regions 0, 4 and 5.
    '{1'b1, CfgHsv,      '{8'h7B, 8'h00, 8'hC8, 1'b0}, 1'b1, 24'hC8C8C8},
    '{1'b0, CfgHsv,      '{8'h00, 8'hFF, 8'hFF, 1'b0}, 1'b0, 24'h0},
    '{1'b0, CfgHsv,      '{8'h2A, 8'hFF, 8'hFF, 1'b0}, 1'b0, 24'h0},
    '{1'b0, CfgHsv,      '{8'h2B, 8'hC0, 8'hE0, 1'b0}, 1'b0, 24'h0},
    '{1'b0, CfgHsv,      '{8'h56, 8'hFF, 8'h80, 1'b0}, 1'b0, 24'h0},
    '{1'b0, CfgHsv,      '{8'h81, 8'h80, 8'hFF, 1'b0}, 1'b0, 24'h0},
    '{1'b0, CfgHsv,      '{8'hAC, 8'hFF, 8'hFF, 1'b0}, 1'b0, 24'h0},
    '{1'b0, CfgHsv,      '{8'hD6, 8'hFF, 8'hFF, 1'b0}, 1'b0, 24'h0},
    '{1'b0, CfgHsv,      '{8'hD7, 8'hFF, 8'hFF, 1'b0}, 1'b0, 24'h0},
    '{1'b0, CfgHsv,      '{8'hFF, 8'h01, 8'hFF, 1'b1}, 1'b0, 24'h0},
    // Zero value is black whatever the hue and saturation.
    '{1'b0, CfgHsv,      '{8'h5F, 8'hA0, 8'h00, 1'b1}, 1'b1, 24'h000000},
    // Duties above the nominal range go out unclamped.
    '{1'b1, CfgWide,     '{8'hF0, 8'h0F, 8'h3C, 1'b0}, 1'b1, 24'hF00F3C},
    '{1'b0, CfgWide,     '{8'h00, 8'hFF, 8'h00, 1'b1}, 1'b1, 24'h00FF00},
    '{1'b1, CfgZeroHigh, '{8'hFF, 8'h00, 8'hAA, 1'b1}, 1'b1, 24'hFF00AA},
    '{1'b0, CfgZeroHigh, '{8'h55, 8'hAA, 8'hFF, 1'b0}, 1'b1, 24'h55AAFF},
    '{1'b1, CfgMix,      '{8'hC0, 8'hFF, 8'hFF, 1'b1}, 1'b0, 24'h0}
  };

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_stall_o;
  pix_in_t   in_pix_i    = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  word_out_t out_word_o;
  logic      cfg_valid_i = 1'b0;
  logic      cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i  = '0;

  // Bench copy of the registers, and the duty words still owed by the encoder.
  cfg_t        cfg_now = CfgReset;
  word_out_t   words_due [$];
  int          err_count = 0;
  int unsigned tx_max_gap = MaxGap;
  bit          rx_calm = 1'b0;
  int unsigned rx_hold = 0;

  led_pixel_pwm_encoder dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_pix_i    (in_pix_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // Colour of one pixel as the serialiser sees it, red in the top byte. In hue mode the
  // hue circle is cut into six regions, five of 43 steps and the last one running from 215 to 255.
  function automatic logic [BitsPerPixel-1:0] pixel_colour(pix_in_t px, logic hsv);
    int unsigned h, s, v, region, rem, p, q, t;
    logic [ChanW-1:0] r, g, b;
    if (!hsv) begin
      return {px.chan_a, px.chan_b, px.chan_c};
    end
    h = px.chan_a;
    s = px.chan_b;
    v = px.chan_c;
    if (s == 0) begin
      return {3{px.chan_c}};
    end
    region = h / HueStep;
    rem    = (h - region * HueStep) * 6;
    p = (v * (ChanMax - s)) >> 8;
    q = (v * (ChanMax - ((s * rem) >> 8))) >> 8;
    t = (v * (ChanMax - ((s * (ChanMax - rem)) >> 8))) >> 8;
    case (region)
      0: begin
        r = 8'(v); g = 8'(t); b = 8'(p);
      end
      1: begin
        r = 8'(q); g = 8'(v); b = 8'(p);
      end
      2: begin
        r = 8'(p); g = 8'(v); b = 8'(t);
      end
      3: begin
        r = 8'(p); g = 8'(q); b = 8'(v);
      end
      4: begin
        r = 8'(t); g = 8'(p); b = 8'(v);
      end
      default: begin
        r = 8'(v); g = 8'(p); b = 8'(q);
      end
    endcase
    return {r, g, b};
  endfunction

  // Queues the 24 duty words of one pixel, most significant bit of red first, and the
  // zero word that closes a frame. The last flag sits on whichever word comes last.
  function automatic void queue_words(logic [BitsPerPixel-1:0] rgb, logic fin);
    word_out_t w;
    for (int i = BitsPerPixel - 1; i >= 0; i--) begin
      w.duty = rgb[i] ? cfg_now.high_duty : cfg_now.low_duty;
      w.last = (i == 0) && !fin;
      words_due.push_back(w);
    end
    if (fin) begin
      w.duty = FrameEndDuty;
      w.last = 1'b1;
      words_due.push_back(w);
    end
  endfunction

  function automatic pix_in_t random_pixel();
    pix_in_t px;
    px.chan_a     = 8'($urandom);
    px.chan_b     = 8'($urandom);
    px.chan_c     = 8'($urandom);
    px.last_pixel = 1'b0;
    // Lean on the corners that matter in hue mode: grey, full value and the top region.
    case ($urandom_range(0, 7))
      0: px.chan_b = '0;
      1: px.chan_c = ChanMax;
      2: px.chan_a = 8'($urandom_range(5 * HueStep, ChanMax));
      default: ;
    endcase
    return px;
  endfunction

  function automatic logic [DutyW-1:0] pick_duty();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return DutyTop;
      2: return '1;
      default: return 8'($urandom_range(1, DutyTop - 1));
    endcase
  endfunction

  // Offers one pixel beat after a random gap and returns at the edge that accepts it.
  // Valid is only lowered for a real gap, so back-to-back beats keep it high.
  task automatic send_pixel(pix_in_t px, bit known, logic [BitsPerPixel-1:0] rgb);
    int unsigned gap;
    gap = $urandom_range(0, tx_max_gap);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_pix_i   <= px;
    do @(posedge clk_i); while (in_stall_o);
    queue_words(known ? rgb : pixel_colour(px, cfg_now.color_mode), px.last_pixel);
  endtask

  // Writes all three registers, then the unmapped index. Spare bits of the mode write are
  // random, since only bit 0 is meant to count.
  task automatic write_cfg(cfg_t c);
    logic [CfgIdxW-1:0]  idx [4];
    logic [CfgDataW-1:0] val [4];
    idx = '{CFG_COLOR_MODE, CFG_HIGH_DUTY, CFG_LOW_DUTY, CfgSpare};
    val = '{{7'($urandom), c.color_mode}, c.high_duty, c.low_duty, 8'($urandom)};
    for (int k = 0; k < 4; k++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= idx[k];
      cfg_data_i  <= val[k];
      do @(posedge clk_i); while (!cfg_ready_o);
    end
    cfg_valid_i <= 1'b0;
    cfg_now = c;
  endtask

  // Every pixel yields words, so once none are owed the encoder holds nothing.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (words_due.size() != 0) @(posedge clk_i);
  endtask

  // Receiver pacing: a random stall before each word, none at all while rx_calm is set,
  // and a long hold-off whenever the stimulus asks for one.
  initial begin : rx_pacing
    int unsigned gap;
    @(posedge rst_ni);
    forever begin
      if (rx_hold > 0) begin
        out_stall_i <= 1'b1;
        repeat (rx_hold) @(posedge clk_i);
        rx_hold = 0;
      end
      gap = rx_calm ? 0 : $urandom_range(0, MaxGap);
      if (gap > 0) begin
        out_stall_i <= 1'b1;
        repeat (gap) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  // Every accepted output beat is matched against the oldest word still owed.
  always @(posedge clk_i) begin : check_words
    word_out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (words_due.size() == 0) begin
        $error("duty word with none owed: duty %0d, last %0b", out_word_o.duty,
               out_word_o.last);
        err_count++;
      end else begin
        want = words_due.pop_front();
        if (out_word_o.duty !== want.duty) begin
          $error("duty: expected %0d, got %0d", want.duty, out_word_o.duty);
          err_count++;
        end
        if (out_word_o.last !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, out_word_o.last);
          err_count++;
        end
      end
    end
  end

  initial begin : stimulus
    pix_in_t     px;
    cfg_t        c;
    int unsigned frame_len;
    int unsigned sent;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed table. Registers only change once every owed word has left.
    foreach (plan[i]) begin
      if (plan[i].load_cfg) begin
        drain();
        write_cfg(plan[i].cfg);
      end
      send_pixel(plan[i].pix, plan[i].known, plan[i].rgb);
    end
    drain();

    // Back pressure: the receiver stops for a long while and the sender keeps offering.
    rx_hold    = PressureHold;
    tx_max_gap = 0;
    repeat (PressurePixels) begin
      px = random_pixel();
      px.last_pixel = 1'(($urandom_range(0, 3) == 0));
      send_pixel(px, 1'b0, '0);
    end
    drain();

    // Random phases of whole frames, the final pixel flagged, with a little noise on the
    // flag. Phase two runs with neither side idling.
    for (int ph = 0; ph < RandomPhases; ph++) begin
      c.color_mode = 1'(ph % 2);
      c.high_duty  = pick_duty();
      c.low_duty   = pick_duty();
      write_cfg(c);
      tx_max_gap = (ph == 2) ? 0 : MaxGap;
      rx_calm    = (ph == 2);
      sent = 0;
      while (sent < PixelsPerPhase) begin
        frame_len = $urandom_range(1, 8);
        for (int k = 0; k < frame_len; k++) begin
          px = random_pixel();
          px.last_pixel = (k == frame_len - 1);
          if ($urandom_range(0, 9) == 0) begin
            px.last_pixel = 1'($urandom_range(0, 1));
          end
          send_pixel(px, 1'b0, '0);
          sent++;
        end
      end
      drain();
    end
    rx_calm = 1'b0;

    // Let the bench idle before the verdict, so that any stray word after the last one is caught.
    repeat (SettleCycles) @(posedge clk_i);
    if (err_count == 0 && words_due.size() == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

  // Ends a run that hangs and reports it as failed.
  initial begin : watchdog
    #1_000_000;
    $display("tb_top: done, errors");
    $finish;
  end

endmodule

// ===== led_pixel_pwm_encoder.f =====
rtl/core/lppe_pkg.sv
rtl/core/lppe_hsv_pipe.sv
rtl/core/lppe_serial.sv
rtl/core/led_pixel_pwm_encoder.sv
verif/tb_top.sv
